// ----- hw/rtl/tlb_fifo_address_translator_top_macros.svh -----
// Assertion macros for the TLB address translator.
`ifndef TLB_FIFO_ADDRESS_TRANSLATOR_TOP_MACROS_SVH
`define TLB_FIFO_ADDRESS_TRANSLATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define TLBFAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define TLBFAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TLBFAT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TLBFAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/tlbfat_pkg.sv -----
// Shared constants, types and helpers of the TLB address translator.
package tlbfat_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int ADDR_BITS       = 16;
    localparam int OFFSET_BITS     = 8;
    localparam int PAGE_BITS       = 8;
    localparam int PAGE_COUNT      = 256;
    localparam int FRAME_BITS      = 8;
    localparam int NEXT_FRAME_BITS = 9;
    localparam int CNT_BITS        = 32;

    // One TLB slot as it moves down the chain
    typedef struct packed {
        logic                  valid;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
    } t_entry;

    // Match result rippled through the chain
    typedef struct packed {
        logic                  match;
        logic [FRAME_BITS-1:0] frame;
    } t_link;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    // Increment that holds at all ones
    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        return (v == {CNT_BITS{1'b1}}) ? v : v + {{(CNT_BITS-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ----- hw/rtl/tlbfat_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tlbfat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/tlbfat_cell.sv -----
// One TLB slot: holds an entry, compares it, and passes entry and match along.
module tlbfat_cell
    import tlbfat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  t_entry               i_entry,
    input  logic [PAGE_BITS-1:0] i_page,
    input  t_link                i_link,
    output t_entry               o_entry,
    output t_link                o_link
);

    logic                  r_valid;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  w_match;

    // Clear the valid bit at reset, take the upstream entry on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_page  <= i_entry.page;
            r_frame <= i_entry.frame;
        end
    end

    // Compare against the lookup page and merge into the match chain
    assign w_match        = r_valid && (r_page == i_page);
    assign o_link.match   = i_link.match | w_match;
    assign o_link.frame   = i_link.frame | (w_match ? r_frame : {FRAME_BITS{1'b0}});

    assign o_entry.valid  = r_valid;
    assign o_entry.page   = r_page;
    assign o_entry.frame  = r_frame;

endmodule

// ----- hw/rtl/tlb_fifo_address_translator_top.sv -----
// Top level of the TLB address translator with FIFO replacement.
//
// Input channel: i_valid / o_stall carry one 16-bit virtual address per
// request; bits 15..8 are the page, bits 7..0 the offset. Output channel:
// o_valid / i_stall carry the physical address, hit and fault flags and the
// three saturating counters for that request.
// Each request passes through ST_IDLE, where the accept edge registers the
// address and starts the page-map read, and ST_LOOK, where the page is
// compared against every TLB slot and the output register is loaded once it
// is free. The input stalls in ST_LOOK, so the next request is taken only
// after that load; ST_LOOK exists for the registered page-map RAM read.
// The TLB is a chain of slots; a miss pushes the new page and frame into the
// first slot and every slot hands its entry on, dropping the oldest, which
// gives FIFO replacement. A page seen for the first time takes the next free
// frame and counts as a fault.
// Reset (synchronous, active low) clears the TLB and page-map valid bits, the
// free-frame counter and all counters at once; no clearing pass is needed.
// While the receiver stalls, the result holds in the output register; one
// more request can be accepted and then waits until the output is taken.
module tlb_fifo_address_translator_top
    import tlbfat_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ADDR_BITS-1:0] i_virtual_address,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ADDR_BITS-1:0] o_physical_address,
    output logic                 o_tlb_hit,
    output logic                 o_page_fault,
    output logic [CNT_BITS-1:0]  o_access_count,
    output logic [CNT_BITS-1:0]  o_hit_count,
    output logic [CNT_BITS-1:0]  o_fault_count
);

    `include "tlb_fifo_address_translator_top_macros.svh"

    t_state r_state;
    t_state n_state;

    logic [PAGE_BITS-1:0]       r_page;
    logic [OFFSET_BITS-1:0]     r_offset;
    logic [PAGE_COUNT-1:0]      r_map_valid;
    logic [NEXT_FRAME_BITS-1:0] r_next_free;
    logic [CNT_BITS-1:0]        r_access_cnt;
    logic [CNT_BITS-1:0]        r_hit_cnt;
    logic [CNT_BITS-1:0]        r_fault_cnt;
    logic                       r_out_valid;
    logic [ADDR_BITS-1:0]       r_out_addr;
    logic                       r_out_hit;
    logic                       r_out_fault;

    logic [CNT_BITS-1:0]        n_access_cnt;
    logic [CNT_BITS-1:0]        n_hit_cnt;
    logic [CNT_BITS-1:0]        n_fault_cnt;

    logic                       w_accept;
    logic                       w_idle;
    logic                       w_load;
    logic                       w_hit;
    logic                       w_map_valid;
    logic                       w_fault;
    logic                       w_shift;
    logic                       w_has_free;
    logic [FRAME_BITS-1:0]      w_map_frame;
    logic [FRAME_BITS-1:0]      w_alloc_frame;
    logic [FRAME_BITS-1:0]      w_frame;
    t_entry                     w_new_entry;
    t_entry                     w_held [TLB_ENTRIES];
    t_link                      w_link [TLB_ENTRIES+1];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_idle = 1'b0;
        unique case (r_state)
            ST_IDLE: w_idle = 1'b1;
            ST_LOOK: w_idle = 1'b0;
            default: w_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall  = !w_idle;
    assign w_accept = i_valid && w_idle;
    assign w_load   = !w_idle && (!r_out_valid || !i_stall);

    // Capture the request address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= i_virtual_address[OFFSET_BITS +: PAGE_BITS];
            r_offset <= i_virtual_address[OFFSET_BITS-1:0];
        end
    end

    // Page-map frames, read at accept and written on a fault
    tlbfat_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (PAGE_COUNT)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load && w_fault),
        .i_wr_addr (r_page),
        .i_wr_data (w_frame),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_virtual_address[OFFSET_BITS +: PAGE_BITS]),
        .o_rd_data (w_map_frame)
    );

    // TLB chain: a miss pushes the new entry in at slot zero
    assign w_new_entry.valid = 1'b1;
    assign w_new_entry.page  = r_page;
    assign w_new_entry.frame = w_frame;
    assign w_link[0]         = '0;

    for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
        tlbfat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry ((k == 0) ? w_new_entry : w_held[(k == 0) ? 0 : k-1]),
            .i_page  (r_page),
            .i_link  (w_link[k]),
            .o_entry (w_held[k]),
            .o_link  (w_link[k+1])
        );
    end

    // Resolve the frame: TLB, then page map, then a fresh allocation
    assign w_hit         = w_link[TLB_ENTRIES].match;
    assign w_map_valid   = r_map_valid[r_page];
    assign w_fault       = !w_hit && !w_map_valid;
    assign w_shift       = w_load && !w_hit;
    assign w_has_free    = (r_next_free < NEXT_FRAME_BITS'(PAGE_COUNT));
    assign w_alloc_frame = w_has_free ? r_next_free[FRAME_BITS-1:0]
                                      : FRAME_BITS'(PAGE_COUNT - 1);
    assign w_frame       = w_hit       ? w_link[TLB_ENTRIES].frame :
                           w_map_valid ? w_map_frame : w_alloc_frame;

    // Counter updates for this request
    assign n_access_cnt = sat_inc(r_access_cnt);
    assign n_hit_cnt    = w_hit   ? sat_inc(r_hit_cnt)   : r_hit_cnt;
    assign n_fault_cnt  = w_fault ? sat_inc(r_fault_cnt) : r_fault_cnt;

    // Advance counters, page-map valid bits and the free-frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid  <= '0;
            r_next_free  <= '0;
            r_access_cnt <= '0;
            r_hit_cnt    <= '0;
            r_fault_cnt  <= '0;
        end else if (w_load) begin
            r_access_cnt <= n_access_cnt;
            r_hit_cnt    <= n_hit_cnt;
            r_fault_cnt  <= n_fault_cnt;
            if (w_fault) begin
                r_map_valid[r_page] <= 1'b1;
                if (w_has_free) begin
                    r_next_free <= r_next_free + {{(NEXT_FRAME_BITS-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; holds while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_addr  <= {w_frame, r_offset};
            r_out_hit   <= w_hit;
            r_out_fault <= w_fault;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_out_addr;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_access_count     = r_access_cnt;
    assign o_hit_count        = r_hit_cnt;
    assign o_fault_count      = r_fault_cnt;

    // An accepted request blocks the input while it is in ST_LOOK
    `TLBFAT_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, w_accept, o_stall)
    // A loaded result shows up on the output with its flags consistent
    `TLBFAT_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load,
        o_valid && !(o_tlb_hit && o_page_fault))
    // A fault with frames left takes exactly one new frame
    `TLBFAT_ASSERT_NEXT(a_frame_alloc, i_clk, i_rst_n, w_load && w_fault && w_has_free,
        r_next_free == $past(r_next_free) + {{(NEXT_FRAME_BITS-1){1'b0}}, 1'b1})
    // Slots fill from the front, so a valid oldest slot means a valid newest one
    `TLBFAT_ASSERT_SAME(a_chain_fill, i_clk, i_rst_n, w_held[TLB_ENTRIES-1].valid,
        w_held[0].valid)

endmodule
